// File: hdl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define BOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/bom_pkg.sv
// ----------------------------------------------------------------------------
// bom_pkg
// Shared constants, codes and controller/datapath interface types of the
// block ownership map.
// ----------------------------------------------------------------------------
package bom_pkg;

    localparam int unsigned NUM_BLOCKS_DEF = 64;
    localparam int unsigned NUM_SLOTS_DEF  = 16;

    localparam int unsigned KIND_W      = 3;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned CNT_W       = 7;
    localparam int unsigned LG_W        = 6;
    localparam int unsigned ST_W        = 2;
    localparam int unsigned MK_W        = 2;
    localparam int unsigned USED_W      = 7;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned LOG_DEPTH   = 64;
    localparam int unsigned TBL_W       = SLOT_W + LG_W;

    localparam logic [CNT_W-1:0] MAX_BLOCKS_RST = 7'd64;
    localparam logic [CNT_W-1:0] CNT_CAP        = 7'd64;
    localparam logic [USED_W-1:0] USED_SAT      = 7'd127;

    // operation kinds
    localparam logic [KIND_W-1:0] K_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] K_FREE    = 3'd1;
    localparam logic [KIND_W-1:0] K_EVICT   = 3'd2;
    localparam logic [KIND_W-1:0] K_RESIZE  = 3'd3;
    localparam logic [KIND_W-1:0] K_ARRANGE = 3'd4;
    localparam logic [KIND_W-1:0] K_USED    = 3'd5;

    // result status
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
    localparam logic [ST_W-1:0] ST_OVER    = 2'd3;

    // move kinds
    localparam logic [MK_W-1:0] MK_REPORT = 2'd0;
    localparam logic [MK_W-1:0] MK_COPY   = 2'd1;
    localparam logic [MK_W-1:0] MK_SWAP   = 2'd2;

    // result select
    localparam logic [2:0] RES_STAT  = 3'd0;
    localparam logic [2:0] RES_USED  = 3'd1;
    localparam logic [2:0] RES_PLACE = 3'd2;
    localparam logic [2:0] RES_EVICT = 3'd3;
    localparam logic [2:0] RES_MISS  = 3'd4;
    localparam logic [2:0] RES_PEND  = 3'd5;

    typedef struct packed {
        logic            ld_op;
        logic            e_clr;
        logic            e_inc;
        logic            e_ld_i;
        logic            i_clr;
        logic            i_ld_cur;
        logic            i_ld_cnt;
        logic            i_inc;
        logic            idx_clr;
        logic            tbl_rd;
        logic            idx_rd;
        logic            take;
        logic            free_e;
        logic            free_idx;
        logic            bld_upd;
        logic            save_i;
        logic            swap1;
        logic            swap2;
        logic            pend_ld;
        logic            pend_clr;
        logic            emit;
        logic [2:0]      res;
        logic [ST_W-1:0] st;
        logic            last;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              kind_bad;
        logic              slot_bad;
        logic              cnt_zero;
        logic              alloc_fail;
        logic              over;
        logic              grow;
        logic              grow_nomem;
        logic              e_end;
        logic              i_eq_cnt;
        logic              i_last;
        logic              i_ge64;
        logic              shr_done;
        logic              locv_i;
        logic              valid_e;
        logic              own_hit;
        logic              mv_hit;
        logic              e_eq_i;
        logic              pend_v;
        logic              out_free;
    } t_sts;

endpackage

// File: hdl/bom_ram.sv
// ----------------------------------------------------------------------------
// bom_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bom_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bom_datapath.sv
// ----------------------------------------------------------------------------
// bom_datapath
// Ownership table, per-operation logical index, counters, move buffer and
// result register of the block ownership map.
// ----------------------------------------------------------------------------
module bom_datapath import bom_pkg::*; #(
    parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_tdata,
    input  logic [KIND_W-1:0]      i_tuser,
    input  logic                   i_cfg_valid,
    input  logic [CNT_W-1:0]       i_cfg_data,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [MK_W-1:0]        o_m_tuser,
    output logic                   o_m_tlast
);

    localparam int unsigned EW = $clog2(NUM_BLOCKS);
    localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);

    // latched operation and configuration
    logic [KIND_W-1:0] r_kind;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_cur;
    logic [CNT_W-1:0]  r_nb;
    logic [CNT_W-1:0]  r_max;

    logic [CW-1:0]     r_e;
    logic [CNT_W-1:0]  r_i;
    logic [CW-1:0]     r_used;
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [LOG_DEPTH-1:0]  r_locv;

    logic [TBL_W-1:0]  r_di;
    logic              r_vi;
    logic              r_pv;
    logic [LG_W-1:0]   r_pphys;
    logic [LG_W-1:0]   r_ppart;
    logic [LG_W-1:0]   r_plg;
    logic [MK_W-1:0]   r_pmk;

    logic              r_ovalid;
    logic [ST_W-1:0]   r_ost;
    logic [LG_W-1:0]   r_ophys;
    logic [LG_W-1:0]   r_opart;
    logic [LG_W-1:0]   r_olg;
    logic [MK_W-1:0]   r_omk;
    logic [USED_W-1:0] r_oused;
    logic              r_olast;

    logic [ST_W-1:0]   n_st;
    logic [LG_W-1:0]   n_phys;
    logic [LG_W-1:0]   n_part;
    logic [LG_W-1:0]   n_lg;
    logic [MK_W-1:0]   n_mk;
    logic [USED_W-1:0] n_used;
    logic              n_last;

    logic [EW-1:0]     e_idx;
    logic [EW-1:0]     i_idx;
    logic [TBL_W-1:0]  tbl_rd;
    logic [EW-1:0]     idx_rd;
    logic [SLOT_W-1:0] tbl_owner;
    logic [LG_W-1:0]   tbl_lg;
    logic [CW-1:0]     free_n;
    logic [8:0]        room;
    logic              own_hit;
    logic              bld_we;
    logic              out_free;
    logic              i_last;
    logic [USED_W-1:0] used_sat;

    logic              tbl_we;
    logic [EW-1:0]     tbl_waddr;
    logic [TBL_W-1:0]  tbl_wdata;
    logic              v_we;
    logic [EW-1:0]     v_addr;
    logic              v_data;

    assign e_idx     = r_e[EW-1:0];
    assign i_idx     = EW'(r_i);
    assign tbl_owner = tbl_rd[TBL_W-1:LG_W];
    assign tbl_lg    = tbl_rd[LG_W-1:0];
    assign free_n    = CW'(NUM_BLOCKS) - r_used;
    assign room      = (9'(r_nb) >= 9'(NUM_BLOCKS)) ? 9'd1 : 9'(NUM_BLOCKS) - 9'(r_nb);
    assign own_hit   = r_valid[e_idx] && (tbl_owner == r_slot);
    assign bld_we    = i_cmd.bld_upd && own_hit && !r_locv[tbl_lg];
    assign out_free  = !r_ovalid || i_m_tready;
    assign i_last    = (8'(r_i) + 8'd1) == 8'(r_count);
    assign used_sat  = (9'(r_used) > 9'(USED_SAT)) ? USED_SAT : USED_W'(r_used);

    always_comb begin
        o_sts            = '0;
        o_sts.kind       = r_kind;
        o_sts.kind_bad   = r_kind > K_USED;
        o_sts.slot_bad   = 9'(r_slot) >= 9'(NUM_SLOTS);
        o_sts.cnt_zero   = r_count == '0;
        o_sts.alloc_fail = (r_count > CNT_CAP) || (9'(free_n) < 9'(r_count));
        o_sts.grow       = r_count > r_cur;
        o_sts.over       = (r_count > r_max) || (r_count > CNT_CAP)
                           || ((r_count > r_cur) && (9'(r_count) > room));
        o_sts.grow_nomem = 9'(free_n) < 9'(r_count - r_cur);
        o_sts.e_end      = 9'(r_e) == 9'(NUM_BLOCKS);
        o_sts.i_eq_cnt   = r_i == r_count;
        o_sts.i_last     = i_last;
        o_sts.i_ge64     = r_i >= CNT_CAP;
        o_sts.shr_done   = (r_i >= r_cur) || (r_i >= CNT_CAP);
        o_sts.locv_i     = r_locv[r_i[LG_W-1:0]];
        o_sts.valid_e    = r_valid[e_idx];
        o_sts.own_hit    = own_hit;
        o_sts.mv_hit     = own_hit && (tbl_lg == r_i[LG_W-1:0]);
        o_sts.e_eq_i     = 9'(r_e) == 9'(r_i);
        o_sts.pend_v     = r_pv;
        o_sts.out_free   = out_free;
    end

    // table write port: placement, or the two halves of an exchange
    assign tbl_we    = i_cmd.take || i_cmd.swap1 || i_cmd.swap2;
    assign tbl_waddr = i_cmd.swap1 ? i_idx : e_idx;
    assign tbl_wdata = i_cmd.take  ? {r_slot, r_i[LG_W-1:0]} :
                       i_cmd.swap1 ? tbl_rd : r_di;

    assign v_we   = i_cmd.take || i_cmd.free_e || i_cmd.free_idx
                    || i_cmd.swap1 || i_cmd.swap2;
    assign v_addr = i_cmd.free_idx ? idx_rd : (i_cmd.swap1 ? i_idx : e_idx);
    assign v_data = (i_cmd.take || i_cmd.swap1) ? 1'b1 : (i_cmd.swap2 ? r_vi : 1'b0);

    bom_ram #(.WIDTH(TBL_W), .DEPTH(NUM_BLOCKS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (i_cmd.tbl_rd),
        .i_raddr (e_idx),
        .o_rdata (tbl_rd)
    );

    // logical block -> lowest entry of the slot, rebuilt for evict, resize and arrange
    bom_ram #(.WIDTH(EW), .DEPTH(LOG_DEPTH)) u_idx (
        .i_clk   (i_clk),
        .i_we    (bld_we),
        .i_waddr (tbl_lg),
        .i_wdata (e_idx),
        .i_re    (i_cmd.idx_rd),
        .i_raddr (r_i[LG_W-1:0]),
        .o_rdata (idx_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_op) begin
            r_kind  <= i_tuser;
            r_slot  <= i_tdata[3:0];
            r_count <= i_tdata[10:4];
            r_cur   <= i_tdata[17:11];
            r_nb    <= i_tdata[24:18];
        end
        if (i_cmd.e_clr) begin
            r_e <= '0;
        end else if (i_cmd.e_ld_i) begin
            r_e <= CW'(r_i);
        end else if (i_cmd.e_inc) begin
            r_e <= r_e + 1'b1;
        end
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_ld_cur) begin
            r_i <= r_cur;
        end else if (i_cmd.i_ld_cnt) begin
            r_i <= r_count;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.save_i) begin
            r_di <= tbl_rd;
            r_vi <= r_valid[e_idx];
        end
        if (i_cmd.pend_ld) begin
            r_pphys <= r_i[LG_W-1:0];
            r_ppart <= LG_W'(r_e);
            r_plg   <= r_i[LG_W-1:0];
            r_pmk   <= r_vi ? MK_SWAP : MK_COPY;
        end
        if (i_cmd.emit) begin
            r_ost   <= n_st;
            r_ophys <= n_phys;
            r_opart <= n_part;
            r_olg   <= n_lg;
            r_omk   <= n_mk;
            r_oused <= n_used;
            r_olast <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= MAX_BLOCKS_RST;
            r_used   <= '0;
            r_valid  <= '0;
            r_locv   <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_used <= r_used + 1'b1;
            end else if (i_cmd.free_e || i_cmd.free_idx) begin
                r_used <= r_used - 1'b1;
            end
            if (v_we) begin
                r_valid[v_addr] <= v_data;
            end
            if (i_cmd.idx_clr) begin
                r_locv <= '0;
            end else if (bld_we) begin
                r_locv[tbl_lg] <= 1'b1;
            end
            if (i_cmd.pend_clr) begin
                r_pv <= 1'b0;
            end else if (i_cmd.pend_ld) begin
                r_pv <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_st   = ST_OK;
        n_phys = '0;
        n_part = '0;
        n_lg   = '0;
        n_mk   = MK_REPORT;
        n_used = '0;
        n_last = 1'b1;
        case (i_cmd.res)
            RES_STAT:  n_st = i_cmd.st;
            RES_USED:  n_used = used_sat;
            RES_PLACE: begin
                n_phys = LG_W'(r_e);
                n_lg   = r_i[LG_W-1:0];
                n_last = i_last;
            end
            RES_EVICT: begin
                n_phys = LG_W'(idx_rd);
                n_lg   = r_i[LG_W-1:0];
                n_last = i_last;
            end
            RES_MISS: begin
                n_st = ST_MISSING;
                n_lg = r_i[LG_W-1:0];
            end
            RES_PEND: begin
                n_phys = r_pphys;
                n_part = r_ppart;
                n_lg   = r_plg;
                n_mk   = r_pmk;
                n_last = i_cmd.last;
            end
            default: n_st = ST_OK;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_oused, r_olg, r_opart, r_ophys, r_ost};
    assign o_m_tuser  = r_omk;
    assign o_m_tlast  = r_olast;

endmodule

// File: hdl/bom_ctrl.sv
// ----------------------------------------------------------------------------
// bom_ctrl
// Operation sequencer: walks the table scans, index build, checks and moves.
// ----------------------------------------------------------------------------
module bom_ctrl import bom_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_ALLOC   = 5'd2;
    localparam logic [4:0] S_FREE_RD = 5'd3;
    localparam logic [4:0] S_FREE_CK = 5'd4;
    localparam logic [4:0] S_GROW    = 5'd5;
    localparam logic [4:0] S_BLD_RD  = 5'd6;
    localparam logic [4:0] S_BLD_CK  = 5'd7;
    localparam logic [4:0] S_SHR_RD  = 5'd8;
    localparam logic [4:0] S_SHR_CK  = 5'd9;
    localparam logic [4:0] S_CHK     = 5'd10;
    localparam logic [4:0] S_EV_RD   = 5'd11;
    localparam logic [4:0] S_EV_CK   = 5'd12;
    localparam logic [4:0] S_MV_TOP  = 5'd13;
    localparam logic [4:0] S_MV_RD   = 5'd14;
    localparam logic [4:0] S_MV_CK   = 5'd15;
    localparam logic [4:0] S_SW1     = 5'd16;
    localparam logic [4:0] S_SW2     = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_shr;
    logic       n_shr;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_shr   = r_shr;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.ld_op = 1'b1;
                    n_shr       = 1'b0;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res = RES_STAT;
                if (i_sts.kind_bad || (i_sts.kind != K_USED && i_sts.slot_bad)) begin
                    n_state = S_IDLE;
                end else begin
                    case (i_sts.kind)
                        K_USED: begin
                            o_cmd.res = RES_USED;
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end
                        K_ALLOC: begin
                            if (i_sts.alloc_fail || i_sts.cnt_zero) begin
                                o_cmd.st = i_sts.alloc_fail ? ST_NOMEM : ST_OK;
                                if (i_sts.out_free) begin
                                    o_cmd.emit = 1'b1;
                                    n_state    = S_IDLE;
                                end
                            end else begin
                                o_cmd.e_clr = 1'b1;
                                o_cmd.i_clr = 1'b1;
                                n_state     = S_ALLOC;
                            end
                        end
                        K_FREE: begin
                            o_cmd.e_clr = 1'b1;
                            n_state     = S_FREE_RD;
                        end
                        K_EVICT: begin
                            if (i_sts.cnt_zero) begin
                                o_cmd.st = ST_NOMEM;
                                if (i_sts.out_free) begin
                                    o_cmd.emit = 1'b1;
                                    n_state    = S_IDLE;
                                end
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                o_cmd.e_clr   = 1'b1;
                                n_state       = S_BLD_RD;
                            end
                        end
                        K_RESIZE: begin
                            if (i_sts.over || (i_sts.grow && i_sts.grow_nomem)) begin
                                o_cmd.st = i_sts.over ? ST_OVER : ST_NOMEM;
                                if (i_sts.out_free) begin
                                    o_cmd.emit = 1'b1;
                                    n_state    = S_IDLE;
                                end
                            end else if (i_sts.grow) begin
                                o_cmd.e_clr    = 1'b1;
                                o_cmd.i_ld_cur = 1'b1;
                                n_state        = S_GROW;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                o_cmd.e_clr   = 1'b1;
                                n_state       = S_BLD_RD;
                            end
                        end
                        default: begin
                            o_cmd.idx_clr = 1'b1;
                            o_cmd.e_clr   = 1'b1;
                            n_state       = S_BLD_RD;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                o_cmd.res = RES_PLACE;
                if (!i_sts.valid_e) begin
                    if (i_sts.out_free) begin
                        o_cmd.take  = 1'b1;
                        o_cmd.emit  = 1'b1;
                        o_cmd.i_inc = 1'b1;
                        o_cmd.e_inc = 1'b1;
                        if (i_sts.i_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    o_cmd.e_inc = 1'b1;
                end
            end
            S_FREE_RD: begin
                if (i_sts.e_end) begin
                    o_cmd.res = RES_STAT;
                    o_cmd.st  = ST_OK;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.tbl_rd = 1'b1;
                    n_state      = S_FREE_CK;
                end
            end
            S_FREE_CK: begin
                o_cmd.free_e = i_sts.own_hit;
                o_cmd.e_inc  = 1'b1;
                n_state      = S_FREE_RD;
            end
            S_GROW: begin
                if (i_sts.i_eq_cnt) begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.e_clr   = 1'b1;
                    n_state       = S_BLD_RD;
                end else begin
                    o_cmd.e_inc = 1'b1;
                    if (!i_sts.valid_e) begin
                        o_cmd.take  = 1'b1;
                        o_cmd.i_inc = 1'b1;
                    end
                end
            end
            S_BLD_RD: begin
                if (i_sts.e_end) begin
                    if (i_sts.kind == K_RESIZE && !i_sts.grow && !r_shr) begin
                        o_cmd.i_ld_cnt = 1'b1;
                        n_state        = S_SHR_RD;
                    end else begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = S_CHK;
                    end
                end else begin
                    o_cmd.tbl_rd = 1'b1;
                    n_state      = S_BLD_CK;
                end
            end
            S_BLD_CK: begin
                o_cmd.bld_upd = 1'b1;
                o_cmd.e_inc   = 1'b1;
                n_state       = S_BLD_RD;
            end
            S_SHR_RD: begin
                if (i_sts.shr_done) begin
                    // rebuild the index over the shrunk image before arranging
                    n_shr         = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.e_clr   = 1'b1;
                    n_state       = S_BLD_RD;
                end else begin
                    o_cmd.idx_rd = 1'b1;
                    n_state      = S_SHR_CK;
                end
            end
            S_SHR_CK: begin
                o_cmd.free_idx = i_sts.locv_i;
                o_cmd.i_inc    = 1'b1;
                n_state        = S_SHR_RD;
            end
            S_CHK: begin
                o_cmd.res = RES_MISS;
                if (i_sts.i_eq_cnt) begin
                    o_cmd.i_clr = 1'b1;
                    if (i_sts.kind == K_EVICT) begin
                        n_state = S_EV_RD;
                    end else begin
                        o_cmd.pend_clr = 1'b1;
                        n_state        = S_MV_TOP;
                    end
                end else if (i_sts.i_ge64 || !i_sts.locv_i) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.i_inc = 1'b1;
                end
            end
            S_EV_RD: begin
                o_cmd.idx_rd = 1'b1;
                n_state      = S_EV_CK;
            end
            S_EV_CK: begin
                o_cmd.res = RES_EVICT;
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.free_idx = 1'b1;
                    o_cmd.i_inc    = 1'b1;
                    n_state        = i_sts.i_last ? S_IDLE : S_EV_RD;
                end
            end
            S_MV_TOP: begin
                if (i_sts.i_eq_cnt) begin
                    o_cmd.res  = i_sts.pend_v ? RES_PEND : RES_STAT;
                    o_cmd.st   = ST_OK;
                    o_cmd.last = 1'b1;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.e_ld_i = 1'b1;
                    n_state      = S_MV_RD;
                end
            end
            S_MV_RD: begin
                o_cmd.tbl_rd = 1'b1;
                n_state      = S_MV_CK;
            end
            S_MV_CK: begin
                o_cmd.save_i = i_sts.e_eq_i;
                if (i_sts.mv_hit) begin
                    if (i_sts.e_eq_i) begin
                        o_cmd.i_inc = 1'b1;
                        n_state     = S_MV_TOP;
                    end else begin
                        n_state = S_SW1;
                    end
                end else begin
                    o_cmd.e_inc = 1'b1;
                    n_state     = S_MV_RD;
                end
            end
            S_SW1: begin
                o_cmd.swap1 = 1'b1;
                n_state     = S_SW2;
            end
            S_SW2: begin
                // hold one move back so the final one can carry last
                o_cmd.res  = RES_PEND;
                o_cmd.last = 1'b0;
                if (!i_sts.pend_v || i_sts.out_free) begin
                    o_cmd.swap2   = 1'b1;
                    o_cmd.emit    = i_sts.pend_v;
                    o_cmd.pend_ld = 1'b1;
                    o_cmd.i_inc   = 1'b1;
                    n_state       = S_MV_TOP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_shr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_shr   <= n_shr;
        end
    end

endmodule

// File: hdl/block_ownership_map.sv
// ----------------------------------------------------------------------------
// block_ownership_map
// Ownership table of fixed-size memory blocks with alloc, free, evict,
// resize, arrange and used-count operations.
// ----------------------------------------------------------------------------
// Usage:
//   One item on the s_axis channel is one operation; the block answers on
//   the m_axis channel with one or more result items, tlast on the final one.
//   Kinds 6 and 7, and slot operations on a slot of NUM_SLOTS or above, give none.
//   The cfg channel writes max_process_blocks; it is always ready and should
//   only be written while no operation is in flight.
// Sequencing (n = count):
//   One operation at a time; s_axis_tready is high only when idle.
//   used count: a single result. alloc: a scan for free entries. free: a read
//   and check of every entry. evict: index build, n checks, n evictions.
//   arrange/resize: index build (twice for a shrink) + n checks + per logical
//   block a scan of the entries from that position plus any exchange.
//   Every table entry is read through the table RAM's registered read.
// Reset: every block free, max_process_blocks = 64, no result pending.
// Stall: results sit in an output register; while m_axis_tready is low the
//   sequencer holds before its next result, but steps that emit nothing, table writes among them, go on.
// ----------------------------------------------------------------------------
module block_ownership_map import bom_pkg::*; #(
    parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // slot[3:0], count[10:4], current_count[17:11],
    // neighbour_blocks[24:18], zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind[2:0]
    input  logic [KIND_W-1:0]      i_s_axis_tuser,
    // status[1:0], phys_index[7:2], partner_index[13:8],
    // logical_block[19:14], used_blocks[26:20], zero fill
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // move_kind[1:0]
    output logic [MK_W-1:0]        o_m_axis_tuser,
    output logic                   o_m_axis_tlast,
    // max_process_blocks
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CNT_W-1:0]       i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Configuration is a plain register write, always accepted.
    assign o_cfg_ready = 1'b1;

    bom_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bom_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

// File: hdl/bom_checker.sv
// ----------------------------------------------------------------------------
// bom_checker
// Port-level assertions for the block ownership map, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bom_checker import bom_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [MK_W-1:0]        o_m_axis_tuser,
    input logic                   o_m_axis_tlast
);

    logic                          in_fire;
    logic                          out_stall;
    logic [OUT_TDATA_W+MK_W+1:0]   out_word;
    logic                          out_fail;
    logic                          out_move;
    logic                          move_clean;

    assign in_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word   = {o_m_axis_tvalid, o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};
    assign out_fail   = o_m_axis_tvalid && (o_m_axis_tdata[1:0] != ST_OK);
    assign out_move   = o_m_axis_tvalid && (o_m_axis_tuser != MK_REPORT);
    assign move_clean = (o_m_axis_tdata[1:0] == ST_OK) && (o_m_axis_tdata[26:20] == '0);

    // hold a stalled result
    `BOM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(out_word))

    // one operation at a time: busy right after an accepted item
    `BOM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !o_s_axis_tready)

    // any failure status ends its operation
    `BOM_ASSERT_IMP(a_fail_is_last, i_clk, i_rst_n, out_fail, o_m_axis_tlast)

    // a move result carries ok status and no used count
    `BOM_ASSERT_IMP(a_move_clean, i_clk, i_rst_n, out_move, move_clean)

endmodule

bind block_ownership_map bom_checker u_bom_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
